@@ rtl/alu8f_pkg.sv @@
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types and constants for the 8-bit ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLC  = 5'd10,
        OP_RRC  = 5'd11,
        OP_RL   = 5'd12,
        OP_RR   = 5'd13,
        OP_RLCA = 5'd14,
        OP_RRCA = 5'd15,
        OP_RLA  = 5'd16,
        OP_RRA  = 5'd17,
        OP_SLA  = 5'd18,
        OP_SRA  = 5'd19,
        OP_SWAP = 5'd20,
        OP_SRL  = 5'd21,
        OP_BIT  = 5'd22,
        OP_RES  = 5'd23,
        OP_SET  = 5'd24,
        OP_DAA  = 5'd25,
        OP_CPL  = 5'd26,
        OP_SCF  = 5'd27,
        OP_CCF  = 5'd28,
        OP_NOP  = 5'd29
    } t_op;

    localparam logic [4:0] OP_LAST_CODE = 5'd28;

    localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HI_MAX  = 8'h99;
    localparam logic [3:0] DAA_LO_MAX  = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        t_op        op;
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] bi;
        t_flags     f;
    } t_item;

    typedef struct packed {
        logic [7:0] result;
        logic       wr;
        t_flags     f;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/cpu_8bit_alu_with_flags_unit.sv @@
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_unit
// 8-bit ALU with Z/N/H/C flags: arithmetic, logic, rotates, shifts, swap, bit ops, daa and cpl/scf/ccf.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. A transaction is taken every cycle
// while o_stall is low. An accepted transaction is registered in the two-entry
// queue, then passes through the execute stage into the output register. The
// input stalls only when the queue holds two transactions, which happens only
// while the output is stalled. Codes 29 to 31 return operand_a with no
// write-back and all flags unchanged.
module cpu_8bit_alu_with_flags_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [4:0] i_req_type,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic [2:0] i_bit_index,
    input  logic       i_zero_in,
    input  logic       i_subtract_in,
    input  logic       i_half_in,
    input  logic       i_carry_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_result,
    output logic       o_write_result,
    output logic       o_zero_out,
    output logic       o_subtract_out,
    output logic       o_half_out,
    output logic       o_carry_out
);

    logic                   push;
    logic                   pop;
    alu8f_pkg::t_item       item;
    alu8f_pkg::t_item       head;
    alu8f_pkg::t_q_status   q_status;
    alu8f_pkg::t_result     res;

    alu8f_front u_front (
        .i_valid       (i_valid),
        .i_req_type    (i_req_type),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_bit_index   (i_bit_index),
        .i_zero_in     (i_zero_in),
        .i_subtract_in (i_subtract_in),
        .i_half_in     (i_half_in),
        .i_carry_in    (i_carry_in),
        .i_q_full      (q_status.full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_item        (item)
    );

    alu8f_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (item),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    alu8f_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (~q_status.empty),
        .i_head       (head),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_res        (res)
    );

    assign o_result       = res.result;
    assign o_write_result = res.wr;
    assign o_zero_out     = res.f.z;
    assign o_subtract_out = res.f.n;
    assign o_half_out     = res.f.h;
    assign o_carry_out    = res.f.c;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

    a_full_means_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> o_valid)
        else $error("queue full with empty output register");

    a_accept_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_valid || !q_status.empty))
        else $error("accepted transaction vanished");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

endmodule

@@ rtl/alu8f_front.sv @@
// ----------------------------------------------------------------------------
// alu8f_front
// Input side: decodes the operation code and packs the transaction for the queue.
// ----------------------------------------------------------------------------
module alu8f_front (
    input  logic                 i_valid,
    input  logic [4:0]           i_req_type,
    input  logic [7:0]           i_operand_a,
    input  logic [7:0]           i_operand_b,
    input  logic [2:0]           i_bit_index,
    input  logic                 i_zero_in,
    input  logic                 i_subtract_in,
    input  logic                 i_half_in,
    input  logic                 i_carry_in,
    input  logic                 i_q_full,
    output logic                 o_stall,
    output logic                 o_push,
    output alu8f_pkg::t_item     o_item
);

    alu8f_pkg::t_op op;

    always_comb begin
        if (i_req_type <= alu8f_pkg::OP_LAST_CODE) begin
            op = alu8f_pkg::t_op'(i_req_type);
        end else begin
            op = alu8f_pkg::OP_NOP;
        end
    end

    always_comb begin
        o_item.op  = op;
        o_item.a   = i_operand_a;
        o_item.b   = i_operand_b;
        o_item.bi  = i_bit_index;
        o_item.f.z = i_zero_in;
        o_item.f.n = i_subtract_in;
        o_item.f.h = i_half_in;
        o_item.f.c = i_carry_in;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;

endmodule

@@ rtl/alu8f_queue.sv @@
// ----------------------------------------------------------------------------
// alu8f_queue
// Two-entry queue between the decode side and the execute side.
// ----------------------------------------------------------------------------
module alu8f_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  alu8f_pkg::t_item       i_item,
    input  logic                   i_pop,
    output alu8f_pkg::t_item       o_head,
    output alu8f_pkg::t_q_status   o_status
);

    alu8f_pkg::t_item r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = r_count[1];
    assign o_status.empty = (r_count == 2'd0);

endmodule

@@ rtl/alu8f_exec.sv @@
// ----------------------------------------------------------------------------
// alu8f_exec
// Execute side: computes result and flags, holds them in the output register.
// ----------------------------------------------------------------------------
module alu8f_exec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  alu8f_pkg::t_item     i_head,
    input  logic                 i_stall,
    output logic                 o_pop,
    output logic                 o_valid,
    output alu8f_pkg::t_result   o_res
);

    logic               r_valid;
    alu8f_pkg::t_result r_res;
    alu8f_pkg::t_result n_res;

    logic [7:0] a;
    logic [7:0] b;
    logic       ci;
    logic [8:0] sum9;
    logic [4:0] hsum;
    logic [8:0] dif9;
    logic [4:0] hdif;
    logic [7:0] mask;
    logic       daa_hi;
    logic       daa_lo;
    logic [7:0] daa_add;
    logic [7:0] daa_sub;
    logic       zres;

    assign a  = i_head.a;
    assign b  = i_head.b;
    assign ci = ((i_head.op == alu8f_pkg::OP_ADC) || (i_head.op == alu8f_pkg::OP_SBC))
                ? i_head.f.c : 1'b0;

    assign sum9 = {1'b0, a} + {1'b0, b} + {8'd0, ci};
    assign hsum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
    assign dif9 = {1'b0, a} - {1'b0, b} - {8'd0, ci};
    assign hdif = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
    assign mask = 8'd1 << i_head.bi;

    assign daa_hi  = i_head.f.c | (a > alu8f_pkg::DAA_HI_MAX);
    assign daa_lo  = i_head.f.h | (a[3:0] > alu8f_pkg::DAA_LO_MAX);
    assign daa_add = a + (daa_hi ? alu8f_pkg::DAA_HI_ADJ : 8'd0)
                       + (daa_lo ? alu8f_pkg::DAA_LO_ADJ : 8'd0);
    assign daa_sub = a - (i_head.f.c ? alu8f_pkg::DAA_HI_ADJ : 8'd0)
                       - (i_head.f.h ? alu8f_pkg::DAA_LO_ADJ : 8'd0);

    always_comb begin
        n_res.result = a;
        n_res.wr     = 1'b1;
        n_res.f      = i_head.f;
        zres         = 1'b1;
        unique case (i_head.op)
            alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
                n_res.result = sum9[7:0];
                n_res.f.n    = 1'b0;
                n_res.f.h    = hsum[4];
                n_res.f.c    = sum9[8];
            end
            alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
                n_res.result = dif9[7:0];
                n_res.f.n    = 1'b1;
                n_res.f.h    = hdif[4];
                n_res.f.c    = dif9[8];
                n_res.wr     = (i_head.op != alu8f_pkg::OP_CP);
            end
            alu8f_pkg::OP_AND: begin
                n_res.result = a & b;
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b1;
                n_res.f.c    = 1'b0;
            end
            alu8f_pkg::OP_XOR: begin
                n_res.result = a ^ b;
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = 1'b0;
            end
            alu8f_pkg::OP_OR: begin
                n_res.result = a | b;
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = 1'b0;
            end
            alu8f_pkg::OP_INC: begin
                n_res.result = a + 8'd1;
                n_res.f.n    = 1'b0;
                n_res.f.h    = (a[3:0] == 4'hF);
            end
            alu8f_pkg::OP_DEC: begin
                n_res.result = a - 8'd1;
                n_res.f.n    = 1'b1;
                n_res.f.h    = (a[3:0] == 4'h0);
            end
            alu8f_pkg::OP_RLC, alu8f_pkg::OP_RLCA: begin
                n_res.result = {a[6:0], a[7]};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[7];
            end
            alu8f_pkg::OP_RRC, alu8f_pkg::OP_RRCA: begin
                n_res.result = {a[0], a[7:1]};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[0];
            end
            alu8f_pkg::OP_RL, alu8f_pkg::OP_RLA: begin
                n_res.result = {a[6:0], i_head.f.c};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[7];
            end
            alu8f_pkg::OP_RR, alu8f_pkg::OP_RRA: begin
                n_res.result = {i_head.f.c, a[7:1]};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[0];
            end
            alu8f_pkg::OP_SLA: begin
                n_res.result = {a[6:0], 1'b0};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[7];
            end
            alu8f_pkg::OP_SRA: begin
                n_res.result = {a[7], a[7:1]};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[0];
            end
            alu8f_pkg::OP_SWAP: begin
                n_res.result = {a[3:0], a[7:4]};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = 1'b0;
            end
            alu8f_pkg::OP_SRL: begin
                n_res.result = {1'b0, a[7:1]};
                n_res.f.n    = 1'b0;
                n_res.f.h    = 1'b0;
                n_res.f.c    = a[0];
            end
            alu8f_pkg::OP_BIT: begin
                n_res.f.z = ~a[i_head.bi];
                n_res.f.n = 1'b0;
                n_res.f.h = 1'b1;
                n_res.wr  = 1'b0;
                zres      = 1'b0;
            end
            alu8f_pkg::OP_RES: begin
                n_res.result = a & ~mask;
                zres         = 1'b0;
            end
            alu8f_pkg::OP_SET: begin
                n_res.result = a | mask;
                zres         = 1'b0;
            end
            alu8f_pkg::OP_DAA: begin
                if (i_head.f.n) begin
                    n_res.result = daa_sub;
                end else begin
                    n_res.result = daa_add;
                    n_res.f.c    = daa_hi;
                end
                n_res.f.h = 1'b0;
            end
            alu8f_pkg::OP_CPL: begin
                n_res.result = ~a;
                n_res.f.n    = 1'b1;
                n_res.f.h    = 1'b1;
                zres         = 1'b0;
            end
            alu8f_pkg::OP_SCF: begin
                n_res.f.c = 1'b1;
                n_res.f.n = 1'b0;
                n_res.f.h = 1'b0;
                n_res.wr  = 1'b0;
                zres      = 1'b0;
            end
            alu8f_pkg::OP_CCF: begin
                n_res.f.c = ~i_head.f.c;
                n_res.f.n = 1'b0;
                n_res.f.h = 1'b0;
                n_res.wr  = 1'b0;
                zres      = 1'b0;
            end
            default: begin
                n_res.wr = 1'b0;
                zres     = 1'b0;
            end
        endcase
        if (zres) begin
            n_res.f.z = (n_res.result == 8'd0);
        end
        // accumulator rotates always clear Z
        if ((i_head.op == alu8f_pkg::OP_RLCA) || (i_head.op == alu8f_pkg::OP_RRCA) ||
            (i_head.op == alu8f_pkg::OP_RLA)  || (i_head.op == alu8f_pkg::OP_RRA)) begin
            n_res.f.z = 1'b0;
        end
    end

    assign o_pop = i_head_valid & (~r_valid | ~i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (~r_valid | ~i_stall) begin
            r_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ tb/alu8f_result_checker.sv @@
// ----------------------------------------------------------------------------
// alu8f_result_checker
// Watches both channels of the 8-bit ALU. Each accepted request is evaluated
// by an independent ALU/flag model and queued; each accepted result is
// compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module alu8f_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [4:0] i_req_type,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic [2:0] i_bit_index,
    input  logic       i_zero_in,
    input  logic       i_subtract_in,
    input  logic       i_half_in,
    input  logic       i_carry_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_result,
    input  logic       i_write_result,
    input  logic       i_zero_out,
    input  logic       i_subtract_out,
    input  logic       i_half_out,
    input  logic       i_carry_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    alu8f_pkg::t_result pending_results[$];
    int      mismatch_count = 0;
    int      compared_count = 0;
    int      owed_count     = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = owed_count;
    assign o_checked    = compared_count;

    function automatic alu8f_pkg::t_result alu_eval(
        input logic [4:0]        op,
        input logic [7:0]        a,
        input logic [7:0]        b,
        input logic [2:0]        bi,
        input alu8f_pkg::t_flags fi
    );
        alu8f_pkg::t_result res;
        logic [9:0] wide;
        logic       cin;
        logic       z_from_result;
        res.result    = a;
        res.wr        = 1'b1;
        res.f         = fi;
        cin           = 1'b0;
        z_from_result = 1'b1;
        wide          = '0;
        case (op)
            alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
                cin        = (op == alu8f_pkg::OP_ADC) ? fi.c : 1'b0;
                wide       = {2'b00, a} + {2'b00, b} + {9'd0, cin};
                res.result = wide[7:0];
                res.f.h    = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin}) > 5'd15;
                res.f.c    = wide[8];
                res.f.n    = 1'b0;
            end
            alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
                cin        = (op == alu8f_pkg::OP_SBC) ? fi.c : 1'b0;
                res.result = a - b - {7'd0, cin};
                res.f.h    = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin});
                res.f.c    = {1'b0, a} < ({1'b0, b} + {8'd0, cin});
                res.f.n    = 1'b1;
                if (op == alu8f_pkg::OP_CP) begin
                    res.wr = 1'b0;
                end
            end
            alu8f_pkg::OP_AND: begin
                res.result = a & b;
                res.f.n = 1'b0; res.f.h = 1'b1; res.f.c = 1'b0;
            end
            alu8f_pkg::OP_XOR: begin
                res.result = a ^ b;
                res.f.n = 1'b0; res.f.h = 1'b0; res.f.c = 1'b0;
            end
            alu8f_pkg::OP_OR: begin
                res.result = a | b;
                res.f.n = 1'b0; res.f.h = 1'b0; res.f.c = 1'b0;
            end
            alu8f_pkg::OP_INC: begin
                res.result = a + 8'd1;
                res.f.h    = (a[3:0] == 4'hF);
                res.f.n    = 1'b0;
            end
            alu8f_pkg::OP_DEC: begin
                res.result = a - 8'd1;
                res.f.h    = (a[3:0] == 4'h0);
                res.f.n    = 1'b1;
            end
            alu8f_pkg::OP_RLC, alu8f_pkg::OP_RLCA: begin
                res.result = {a[6:0], a[7]};
                res.f.c = a[7]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_RRC, alu8f_pkg::OP_RRCA: begin
                res.result = {a[0], a[7:1]};
                res.f.c = a[0]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_RL, alu8f_pkg::OP_RLA: begin
                res.result = {a[6:0], fi.c};
                res.f.c = a[7]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_RR, alu8f_pkg::OP_RRA: begin
                res.result = {fi.c, a[7:1]};
                res.f.c = a[0]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_SLA: begin
                res.result = {a[6:0], 1'b0};
                res.f.c = a[7]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_SRA: begin
                res.result = {a[7], a[7:1]};
                res.f.c = a[0]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_SWAP: begin
                res.result = {a[3:0], a[7:4]};
                res.f.c = 1'b0; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_SRL: begin
                res.result = {1'b0, a[7:1]};
                res.f.c = a[0]; res.f.n = 1'b0; res.f.h = 1'b0;
            end
            alu8f_pkg::OP_BIT: begin
                res.f.z = ~a[bi];
                res.f.n = 1'b0;
                res.f.h = 1'b1;
                res.wr  = 1'b0;
                z_from_result = 1'b0;
            end
            alu8f_pkg::OP_RES: begin
                res.result    = a & ~(8'd1 << bi);
                z_from_result = 1'b0;
            end
            alu8f_pkg::OP_SET: begin
                res.result    = a | (8'd1 << bi);
                z_from_result = 1'b0;
            end
            alu8f_pkg::OP_DAA: begin
                if (fi.n) begin
                    if (fi.c) begin
                        res.result = res.result - alu8f_pkg::DAA_HI_ADJ;
                    end
                    if (fi.h) begin
                        res.result = res.result - alu8f_pkg::DAA_LO_ADJ;
                    end
                end else begin
                    if (fi.c || a > alu8f_pkg::DAA_HI_MAX) begin
                        res.result = res.result + alu8f_pkg::DAA_HI_ADJ;
                        res.f.c    = 1'b1;
                    end
                    if (fi.h || a[3:0] > alu8f_pkg::DAA_LO_MAX) begin
                        res.result = res.result + alu8f_pkg::DAA_LO_ADJ;
                    end
                end
                res.f.h = 1'b0;
            end
            alu8f_pkg::OP_CPL: begin
                res.result = ~a;
                res.f.n = 1'b1; res.f.h = 1'b1;
                z_from_result = 1'b0;
            end
            alu8f_pkg::OP_SCF: begin
                res.f.c = 1'b1; res.f.n = 1'b0; res.f.h = 1'b0;
                res.wr  = 1'b0;
                z_from_result = 1'b0;
            end
            alu8f_pkg::OP_CCF: begin
                res.f.c = ~fi.c; res.f.n = 1'b0; res.f.h = 1'b0;
                res.wr  = 1'b0;
                z_from_result = 1'b0;
            end
            default: begin
                res.wr        = 1'b0;
                z_from_result = 1'b0;
            end
        endcase
        if (z_from_result) begin
            res.f.z = (res.result == 8'h00);
        end
        if (op == alu8f_pkg::OP_RLCA || op == alu8f_pkg::OP_RRCA ||
            op == alu8f_pkg::OP_RLA  || op == alu8f_pkg::OP_RRA) begin
            res.f.z = 1'b0;
        end
        return res;
    endfunction

    function automatic int field_diff(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        alu8f_pkg::t_result want;
        alu8f_pkg::t_flags  flags_in;
        int                 errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing expected: result %0h", i_result);
                    errs = 1;
                end else begin
                    want = pending_results.pop_front();
                    errs += field_diff("result", int'(want.result), int'(i_result));
                    errs += field_diff("write_result", int'(want.wr), int'(i_write_result));
                    errs += field_diff("zero_out", int'(want.f.z), int'(i_zero_out));
                    errs += field_diff("subtract_out", int'(want.f.n),
                                       int'(i_subtract_out));
                    errs += field_diff("half_out", int'(want.f.h), int'(i_half_out));
                    errs += field_diff("carry_out", int'(want.f.c), int'(i_carry_out));
                    compared_count++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                flags_in = {i_zero_in, i_subtract_in, i_half_in, i_carry_in};
                pending_results.push_back(alu_eval(i_req_type, i_operand_a, i_operand_b,
                                                   i_bit_index, flags_in));
            end
        end
        mismatch_count += errs;
        owed_count = pending_results.size();
    end

endmodule

@@ tb/cpu_8bit_alu_with_flags_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_unit_tb
// Drives the ALU with a directed sweep of every operation code, then random
// requests under four mixes of request gaps and result backpressure, and
// reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module cpu_8bit_alu_with_flags_unit_tb;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 470;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RUN_LIMIT       = 4_000_000;
    localparam int NUM_CODES       = 1 << $bits(alu8f_pkg::t_op);

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_stall       = 1'b0;
    logic [4:0] i_req_type    = '0;
    logic [7:0] i_operand_a   = '0;
    logic [7:0] i_operand_b   = '0;
    logic [2:0] i_bit_index   = '0;
    logic       i_zero_in     = 1'b0;
    logic       i_subtract_in = 1'b0;
    logic       i_half_in     = 1'b0;
    logic       i_carry_in    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_result;
    logic       o_write_result;
    logic       o_zero_out;
    logic       o_subtract_out;
    logic       o_half_out;
    logic       o_carry_out;

    int fail_total;
    int results_owed;
    int results_seen;
    int sent_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic [7:0] corner_bytes [0:8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80,
                                       8'h7F, 8'h01, 8'h99, 8'h9A};

    cpu_8bit_alu_with_flags_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_bit_index    (i_bit_index),
        .i_zero_in      (i_zero_in),
        .i_subtract_in  (i_subtract_in),
        .i_half_in      (i_half_in),
        .i_carry_in     (i_carry_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (o_result),
        .o_write_result (o_write_result),
        .o_zero_out     (o_zero_out),
        .o_subtract_out (o_subtract_out),
        .o_half_out     (o_half_out),
        .o_carry_out    (o_carry_out)
    );

    alu8f_result_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_bit_index    (i_bit_index),
        .i_zero_in      (i_zero_in),
        .i_subtract_in  (i_subtract_in),
        .i_half_in      (i_half_in),
        .i_carry_in     (i_carry_in),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_result       (o_result),
        .i_write_result (o_write_result),
        .i_zero_out     (o_zero_out),
        .i_subtract_out (o_subtract_out),
        .i_half_out     (o_half_out),
        .i_carry_out    (o_carry_out),
        .o_fail_count   (fail_total),
        .o_pending      (results_owed),
        .o_checked      (results_seen)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("** cpu_8bit_alu_with_flags_unit: FAILED **");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0) begin
            return corner_bytes[$urandom_range(8)];
        end
        return 8'($urandom());
    endfunction

    task automatic send_txn(
        input logic [4:0] op,
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [2:0] bi,
        input logic [3:0] flags
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_req_type  = op;
        i_operand_a = a;
        i_operand_b = b;
        i_bit_index = bi;
        {i_zero_in, i_subtract_in, i_half_in, i_carry_in} = flags;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (results_owed != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int         k;
        int         phase;
        logic [7:0] a;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sweep every code, unused ones included
        for (k = 0; k < NUM_CODES; k++) begin
            a = corner_bytes[k % 9];
            send_txn(5'(k), a, (k % 5 == 0) ? a : corner_bytes[(k * 7) % 9],
                     3'(k), (k >= 16) ? ~4'(k) : 4'(k));
        end
        send_txn(alu8f_pkg::OP_ADC, 8'hFF, 8'h00, 3'd0, 4'b0001);
        send_txn(alu8f_pkg::OP_SBC, 8'h00, 8'hFF, 3'd7, 4'b0001);
        send_txn(alu8f_pkg::OP_DAA, 8'h9A, 8'h00, 3'd0, 4'b0000);
        send_txn(alu8f_pkg::OP_DAA, 8'h00, 8'h00, 3'd0, 4'b0111);
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_txn(5'($urandom_range(NUM_CODES - 1)), pick_byte(), pick_byte(),
                         3'($urandom_range(7)), 4'($urandom_range(15)));
            end
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d ALU transactions: all %0d codes, corner and random operands,",
                 sent_count, NUM_CODES);
        $display("under four gap/backpressure mixes; %0d results compared, %0d mismatches",
                 results_seen, fail_total);
        if (fail_total == 0 && results_owed == 0) begin
            $display("** cpu_8bit_alu_with_flags_unit: PASSED **");
        end else begin
            $display("** cpu_8bit_alu_with_flags_unit: FAILED **");
        end
        $finish;
    end

endmodule
